// File: design/tsfst_pkg.sv
// shared types and constants for the tcp source flow statistics table
package tsfst_pkg;

  localparam int unsigned FlowEntries  = 256;
  localparam int unsigned PortsPerFlow = 64;
  localparam int unsigned SlotW        = $clog2(FlowEntries);
  localparam int unsigned UsedW        = $clog2(FlowEntries + 1);
  localparam int unsigned PortIdxW     = $clog2(PortsPerFlow);
  localparam int unsigned PortCntW     = $clog2(PortsPerFlow + 1);
  localparam int unsigned ListAddrW    = SlotW + PortIdxW;

  localparam logic [7:0] FlagFin = 8'h01;
  localparam logic [7:0] FlagSyn = 8'h02;
  localparam logic [7:0] FlagRst = 8'h04;
  localparam logic [7:0] FlagAck = 8'h10;

  localparam logic [1:0] StatusExisting = 2'd0;
  localparam logic [1:0] StatusCreated  = 2'd1;
  localparam logic [1:0] StatusFull     = 2'd2;

  typedef struct packed {
    logic [31:0] source_address;
    logic [15:0] destination_port;
    logic [7:0]  tcp_flags;
    logic [31:0] timestamp_seconds;
  } event_t;

  typedef struct packed {
    logic [1:0]  lookup_status;
    logic [7:0]  flow_slot;
    logic [31:0] syn_total;
    logic [31:0] ack_total;
    logic [31:0] rst_total;
    logic [31:0] syn_fin_total;
    logic [6:0]  distinct_port_total;
    logic        port_was_added;
    logic [31:0] first_seen_time;
    logic [31:0] last_seen_time;
  } result_t;

  typedef struct packed {
    logic [31:0]         syn;
    logic [31:0]         ack;
    logic [31:0]         rst;
    logic [31:0]         syn_fin;
    logic [31:0]         born_ts;
    logic [31:0]         recent_ts;
    logic [PortCntW-1:0] port_cnt;
  } stats_t;

  function automatic logic [31:0] sat_inc(logic [31:0] v, logic en);
    return (en && v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
  endfunction

endpackage

// File: design/tsfst_ram.sv
// generic single port synchronous ram with registered read data
module tsfst_ram #(
  parameter int unsigned Depth = 256,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// File: design/tcp_source_flow_stats_table_top.sv
// top level of the tcp source flow statistics table
//
// in channel: one tcp packet event per transaction (in_valid_i, in_stall_o,
// in_data_i). out channel: one statistics result per event (out_valid_o,
// out_stall_i, out_data_o).
// each event is processed alone by a sequencer around three memories: the
// source keys, the per-flow statistics and the per-flow port lists.
// the source search reads and then checks one key at a time over the flows in
// use, then the statistics are read, and for a syn without ack the port list
// is walked one port at a time, read then checked, over that flow's ports.
// up to 256 flows can be in use and up to 64 ports are recorded per flow;
// the next event is taken when the result register is free, so a stalled
// result holds the block after the current event.
// reset clears the flow count and the control state; memory contents are
// left as they are and never read before being written.
// a table full event returns status 2 with all other fields zero.
module tcp_source_flow_stats_table_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  tsfst_pkg::event_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output tsfst_pkg::result_t        out_data_o
);

  typedef enum logic [3:0] {
    StIdle, StSrcRd, StSrcChk, StStatRd, StStatWait, StPortRd, StPortChk,
    StWrite, StOut
  } state_e;

  state_e                        state_q;
  tsfst_pkg::event_t             ev_q;
  logic [tsfst_pkg::UsedW-1:0]   used_q;
  logic [tsfst_pkg::UsedW-1:0]   idx_q;
  logic [tsfst_pkg::PortCntW-1:0] pidx_q;
  logic [tsfst_pkg::SlotW-1:0]   slot_q;
  logic                          created_q;
  logic                          dup_q;
  tsfst_pkg::stats_t             st_q;
  logic                          out_valid_q;
  tsfst_pkg::result_t            out_q;

  logic                               src_we, stat_we, list_we;
  logic [tsfst_pkg::SlotW-1:0]        src_addr, stat_addr;
  logic [tsfst_pkg::ListAddrW-1:0]    list_addr;
  logic [31:0]                        src_rd;
  tsfst_pkg::stats_t                  stat_rd, stat_wd;
  logic [15:0]                        list_rd;
  logic                               probe;

  assign probe = ((ev_q.tcp_flags & tsfst_pkg::FlagSyn) != '0) &&
                 ((ev_q.tcp_flags & tsfst_pkg::FlagAck) == '0);

  assign src_we    = (state_q == StSrcChk) && (idx_q == used_q) &&
                     (used_q != tsfst_pkg::UsedW'(tsfst_pkg::FlowEntries));
  assign src_addr  = (state_q == StSrcChk) ? slot_q
                                           : idx_q[tsfst_pkg::SlotW-1:0];
  assign stat_addr = slot_q;
  assign stat_we   = (state_q == StWrite);
  assign list_we   = (state_q == StWrite) && probe && !dup_q &&
                     (st_q.port_cnt < tsfst_pkg::PortCntW'(tsfst_pkg::PortsPerFlow));
  assign list_addr = {slot_q, list_we ? st_q.port_cnt[tsfst_pkg::PortIdxW-1:0]
                                      : pidx_q[tsfst_pkg::PortIdxW-1:0]};

  always_comb begin
    stat_wd = st_q;
    stat_wd.recent_ts = ev_q.timestamp_seconds;
    stat_wd.syn = tsfst_pkg::sat_inc(st_q.syn,
                  (ev_q.tcp_flags & tsfst_pkg::FlagSyn) != '0);
    stat_wd.ack = tsfst_pkg::sat_inc(st_q.ack,
                  (ev_q.tcp_flags & tsfst_pkg::FlagAck) != '0);
    stat_wd.rst = tsfst_pkg::sat_inc(st_q.rst,
                  (ev_q.tcp_flags & tsfst_pkg::FlagRst) != '0);
    stat_wd.syn_fin = tsfst_pkg::sat_inc(st_q.syn_fin,
                  ((ev_q.tcp_flags & tsfst_pkg::FlagSyn) != '0) &&
                  ((ev_q.tcp_flags & tsfst_pkg::FlagFin) != '0));
    if (list_we) begin
      stat_wd.port_cnt = st_q.port_cnt + 1'b1;
    end
  end

  tsfst_ram #(.Depth(tsfst_pkg::FlowEntries), .Width(32)) u_src_ram (
    .clk_i, .we_i(src_we), .addr_i(src_addr), .wdata_i(ev_q.source_address),
    .rdata_o(src_rd)
  );

  tsfst_ram #(.Depth(tsfst_pkg::FlowEntries), .Width($bits(tsfst_pkg::stats_t)))
  u_stat_ram (
    .clk_i, .we_i(stat_we), .addr_i(stat_addr), .wdata_i(stat_wd),
    .rdata_o(stat_rd)
  );

  tsfst_ram #(.Depth(tsfst_pkg::FlowEntries * tsfst_pkg::PortsPerFlow), .Width(16))
  u_list_ram (
    .clk_i, .we_i(list_we), .addr_i(list_addr), .wdata_i(ev_q.destination_port),
    .rdata_o(list_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && !out_valid_q) begin
            ev_q    <= in_data_i;
            idx_q   <= '0;
            state_q <= StSrcRd;
          end
        end
        StSrcRd: begin
          state_q <= StSrcChk;
          if (idx_q == used_q) begin
            slot_q  <= idx_q[tsfst_pkg::SlotW-1:0];
          end
        end
        StSrcChk: begin
          if (idx_q == used_q) begin
            if (used_q == tsfst_pkg::UsedW'(tsfst_pkg::FlowEntries)) begin
              out_q   <= '{lookup_status: tsfst_pkg::StatusFull, default: '0};
              state_q <= StOut;
            end else begin
              created_q <= 1'b1;
              used_q    <= used_q + 1'b1;
              st_q      <= '{born_ts: ev_q.timestamp_seconds, default: '0};
              dup_q     <= 1'b0;
              state_q   <= StWrite;
            end
          end else if (src_rd == ev_q.source_address) begin
            created_q <= 1'b0;
            slot_q    <= idx_q[tsfst_pkg::SlotW-1:0];
            state_q   <= StStatRd;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= StSrcRd;
          end
        end
        StStatRd: state_q <= StStatWait;
        StStatWait: begin
          st_q    <= stat_rd;
          dup_q   <= 1'b0;
          pidx_q  <= '0;
          state_q <= (probe && stat_rd.port_cnt != '0) ? StPortRd : StWrite;
        end
        StPortRd: state_q <= StPortChk;
        StPortChk: begin
          if (list_rd == ev_q.destination_port) begin
            dup_q   <= 1'b1;
            state_q <= StWrite;
          end else if (pidx_q + 1'b1 == st_q.port_cnt) begin
            state_q <= StWrite;
          end else begin
            pidx_q  <= pidx_q + 1'b1;
            state_q <= StPortRd;
          end
        end
        StWrite: begin
          out_q.lookup_status <= created_q ? tsfst_pkg::StatusCreated
                                           : tsfst_pkg::StatusExisting;
          out_q.flow_slot     <= 8'(slot_q);
          out_q.syn_total     <= stat_wd.syn;
          out_q.ack_total     <= stat_wd.ack;
          out_q.rst_total     <= stat_wd.rst;
          out_q.syn_fin_total <= stat_wd.syn_fin;
          out_q.distinct_port_total <= 7'(stat_wd.port_cnt);
          out_q.port_was_added <= list_we;
          out_q.first_seen_time <= stat_wd.born_ts;
          out_q.last_seen_time  <= stat_wd.recent_ts;
          state_q <= StOut;
        end
        StOut: begin
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= tsfst_pkg::UsedW'(tsfst_pkg::FlowEntries))
    else $error("flow count beyond table size");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    src_we |=> used_q == $past(used_q) + 1'b1)
    else $error("new flow without count step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    list_we |-> st_q.port_cnt < tsfst_pkg::PortCntW'(tsfst_pkg::PortsPerFlow))
    else $error("port list overflow");

endmodule
